FILE: design/pic_pkg.sv
// shared constants and codes for the palette interpolating colorizer
`timescale 1ns / 1ps
`default_nettype none

package pic_pkg;

    // palette geometry
    localparam int PAL_DEPTH = 128;
    localparam int PAL_AW    = $clog2(PAL_DEPTH);

    // color format
    localparam int CHAN_W = 8;
    localparam int RGB_W  = 3 * CHAN_W;

    // fraction format and rounding
    localparam int FRAC_BITS = 8;
    localparam int FRAC_HALF = 1 << (FRAC_BITS - 1);
    localparam int FRAC_MASK = (1 << FRAC_BITS) - 1;
    localparam int PROD_W    = FRAC_BITS + CHAN_W + 2;

    // input field widths
    localparam int WHOLE_W  = 24;
    localparam int IFRAC_W  = 8;
    localparam int IDATA_W  = 64;
    localparam int ODATA_W  = 24;

    // opcodes carried in s_tuser
    localparam logic OP_MAP   = 1'b0;
    localparam logic OP_WRITE = 1'b1;

    // configuration register indexes
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_ITER_LIMIT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_INSIDE_RGB = 1'b1;

    // configuration reset values
    localparam logic [WHOLE_W-1:0] ITER_LIMIT_RST = 24'd1024;
    localparam logic [RGB_W-1:0]   INSIDE_RGB_RST = 24'd0;

endpackage

`default_nettype wire

FILE: design/pic_chan_blend.sv
// one color channel blend: registered product, then rounding and offset
`timescale 1ns / 1ps
`default_nettype none

module pic_chan_blend (
    input  wire                           aclk,
    input  wire                           load_i,
    input  wire [pic_pkg::CHAN_W-1:0]     c1_i,
    input  wire [pic_pkg::CHAN_W-1:0]     c2_i,
    input  wire [pic_pkg::FRAC_BITS-1:0]  frac_i,
    output logic [pic_pkg::CHAN_W-1:0]    chan_o
);
    import pic_pkg::*;

    logic signed [CHAN_W:0]   diff_c;
    logic signed [PROD_W-1:0] prod_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic [CHAN_W-1:0]        c1_reg;
    logic signed [PROD_W-1:0] num_c;
    logic signed [PROD_W-1:0] bias_c;
    logic signed [PROD_W-1:0] adj_c;
    logic signed [PROD_W-1:0] q_c;

    // signed difference times the fraction
    assign diff_c    = $signed({1'b0, c2_i}) - $signed({1'b0, c1_i});
    assign prod_next = PROD_W'($signed({1'b0, frac_i}) * diff_c);

    always_ff @(posedge aclk) begin
        if (load_i) begin
            prod_reg <= prod_next;
            c1_reg   <= c1_i;
        end
    end

    // add half, then divide rounding toward zero
    assign num_c  = prod_reg + $signed(PROD_W'(FRAC_HALF));
    assign bias_c = num_c[PROD_W-1] ? PROD_W'(FRAC_MASK) : '0;
    assign adj_c  = num_c + bias_c;
    assign q_c    = adj_c >>> FRAC_BITS;
    assign chan_o = c1_reg + q_c[CHAN_W-1:0];

endmodule

`default_nettype wire

FILE: design/palette_interp_colorizer.sv
// top level: palette memory, read pipeline and blended color output
// a map item passes the stage 1 palette read, the stage 2 blend products and the output register to reach m_tvalid
// throughput: one item per clock unless stalled; both entries come from one dual-read palette memory
// write items store into the palette at their transfer and give no result
// a stalled output holds the pipeline only as far back as the stages are full
// reset: synchronous active-low aresetn clears the pipeline and loads register defaults
// palette contents are not cleared and are undefined until written
`timescale 1ns / 1ps
`default_nettype none

module palette_interp_colorizer (
    input  wire                             aclk,
    input  wire                             aresetn,
    // configuration writes
    input  wire                             cfg_we,
    input  wire [pic_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire [pic_pkg::RGB_W-1:0]        cfg_wdata,
    // input stream
    input  wire                             s_tvalid,
    output logic                            s_tready,
    // iter_whole[23:0], iter_frac[31:24], point_inside[32],
    // entry_slot[39:33], entry_rgb[63:40]
    input  wire [pic_pkg::IDATA_W-1:0]      s_tdata,
    // opcode[0]
    input  wire [0:0]                       s_tuser,
    // result stream
    output logic                            m_tvalid,
    input  wire                             m_tready,
    // out_red[7:0], out_green[15:8], out_blue[23:16]
    output logic [pic_pkg::ODATA_W-1:0]     m_tdata,
    // was_inside[0]
    output logic [0:0]                      m_tuser
);
    import pic_pkg::*;

    // input field slices
    logic [WHOLE_W-1:0]   in_whole;
    logic [IFRAC_W-1:0]   in_frac;
    logic                 in_inside;
    logic [PAL_AW-1:0]    in_slot;
    logic [RGB_W-1:0]     in_rgb;
    logic                 in_write;

    assign in_whole  = s_tdata[23:0];
    assign in_frac   = s_tdata[31:24];
    assign in_inside = s_tdata[32];
    assign in_slot   = s_tdata[39:33];
    assign in_rgb    = s_tdata[63:40];
    assign in_write  = (s_tuser[0] == OP_WRITE);

    // configuration registers
    logic [WHOLE_W-1:0] iter_limit_reg;
    logic [RGB_W-1:0]   inside_rgb_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iter_limit_reg <= ITER_LIMIT_RST;
            inside_rgb_reg <= INSIDE_RGB_RST;
        end else if (cfg_we) begin
            case (cfg_index)
                CFG_ITER_LIMIT: iter_limit_reg <= cfg_wdata;
                CFG_INSIDE_RGB: inside_rgb_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // stage enables, each stage moves when it is empty or the next one moves
    logic s1_valid_reg;
    logic s2_valid_reg;
    logic m_valid_reg;
    logic en_out;
    logic en2;
    logic en1;
    logic in_xfer;
    logic map_xfer;

    assign en_out   = !m_valid_reg || m_tready;
    assign en2      = !s2_valid_reg || en_out;
    assign en1      = !s1_valid_reg || en2;
    assign s_tready = en1;
    assign in_xfer  = s_tvalid && en1;
    assign map_xfer = in_xfer && !in_write;

    // palette entry pair addresses, upper entry wraps to zero
    logic [PAL_AW-1:0] idx_lo;
    logic [PAL_AW-1:0] idx_hi;

    assign idx_lo = in_whole[PAL_AW-1:0];
    assign idx_hi = (idx_lo == PAL_AW'(PAL_DEPTH - 1)) ? '0 : idx_lo + 1'b1;

    // palette memory: one write port, two registered read ports
    logic [RGB_W-1:0] pal_mem [PAL_DEPTH];
    logic [RGB_W-1:0] rd_lo_reg;
    logic [RGB_W-1:0] rd_hi_reg;

    always_ff @(posedge aclk) begin
        if (in_xfer && in_write) begin
            pal_mem[in_slot] <= in_rgb;
        end
        if (map_xfer) begin
            rd_lo_reg <= pal_mem[idx_lo];
            rd_hi_reg <= pal_mem[idx_hi];
        end
    end

    // stage 1: inside decision and fraction alongside the memory read
    logic [FRAC_BITS-1:0] s1_frac_reg;
    logic                 s1_inside_reg;
    logic                 s1_inside_next;

    assign s1_inside_next = in_inside || (in_whole >= iter_limit_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (en1) begin
            s1_valid_reg <= map_xfer;
        end
    end

    always_ff @(posedge aclk) begin
        if (map_xfer) begin
            s1_frac_reg   <= in_frac[FRAC_BITS-1:0];
            s1_inside_reg <= s1_inside_next;
        end
    end

    // stage 2: per-channel products held in the blend units
    logic                s2_inside_reg;
    logic                s2_load;
    logic [CHAN_W-1:0]   blend_r;
    logic [CHAN_W-1:0]   blend_g;
    logic [CHAN_W-1:0]   blend_b;

    assign s2_load = en2 && s1_valid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (en2) begin
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s2_load) begin
            s2_inside_reg <= s1_inside_reg;
        end
    end

    pic_chan_blend u_blend_r (
        .aclk   (aclk),
        .load_i (s2_load),
        .c1_i   (rd_lo_reg[23:16]),
        .c2_i   (rd_hi_reg[23:16]),
        .frac_i (s1_frac_reg),
        .chan_o (blend_r)
    );

    pic_chan_blend u_blend_g (
        .aclk   (aclk),
        .load_i (s2_load),
        .c1_i   (rd_lo_reg[15:8]),
        .c2_i   (rd_hi_reg[15:8]),
        .frac_i (s1_frac_reg),
        .chan_o (blend_g)
    );

    pic_chan_blend u_blend_b (
        .aclk   (aclk),
        .load_i (s2_load),
        .c1_i   (rd_lo_reg[7:0]),
        .c2_i   (rd_hi_reg[7:0]),
        .frac_i (s1_frac_reg),
        .chan_o (blend_b)
    );

    // output register: blended color or inside color
    logic [ODATA_W-1:0] out_data_reg;
    logic [ODATA_W-1:0] out_data_next;
    logic               out_inside_reg;

    assign out_data_next = s2_inside_reg
                         ? {inside_rgb_reg[7:0], inside_rgb_reg[15:8], inside_rgb_reg[23:16]}
                         : {blend_b, blend_g, blend_r};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en_out) begin
            m_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en_out && s2_valid_reg) begin
            out_data_reg   <= out_data_next;
            out_inside_reg <= s2_inside_reg;
        end
    end

    assign m_tvalid   = m_valid_reg;
    assign m_tdata    = out_data_reg;
    assign m_tuser[0] = out_inside_reg;

endmodule

`default_nettype wire

FILE: design/pic_checker.sv
// port-level checks for the colorizer, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module pic_checker (
    input  wire                          aclk,
    input  wire                          aresetn,
    input  wire                          s_tvalid,
    input  wire                          s_tready,
    input  wire [pic_pkg::IDATA_W-1:0]   s_tdata,
    input  wire [0:0]                    s_tuser,
    input  wire                          m_tvalid,
    input  wire                          m_tready,
    input  wire [pic_pkg::ODATA_W-1:0]   m_tdata,
    input  wire [0:0]                    m_tuser
);
    import pic_pkg::*;

    // no result right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("stalled result changed");

    // an empty output means the whole pipeline can take an item
    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input not ready while output empty");

    // a flagged-inside map item with a free-running sink arrives as an inside result
    a_inside_latency: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && s_tuser[0] == OP_MAP && s_tdata[32])
        ##1 m_tready ##1 m_tready |=> m_tvalid && m_tuser[0])
        else $error("inside item missing at fixed latency");

endmodule

bind palette_interp_colorizer pic_checker u_pic_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire

FILE: tb/tb_palette_interp_colorizer.sv
// self-checking testbench for the palette interpolating colorizer
`timescale 1ns / 1ps

module tb_palette_interp_colorizer;
    import pic_pkg::*;

    localparam int CYCLE_LIMIT = 400000;

    // one input item, all fields carried even where the opcode ignores them
    typedef struct packed {
        logic                op;
        logic [WHOLE_W-1:0]  whole;
        logic [IFRAC_W-1:0]  frac;
        logic                is_in;
        logic [PAL_AW-1:0]   slot;
        logic [RGB_W-1:0]    rgb;
    } pix_item_t;

    // one result color
    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              was_in;
    } color_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   cfg_we;
    logic [CFG_IDX_W-1:0]   cfg_index;
    logic [RGB_W-1:0]       cfg_wdata;
    logic                   s_tvalid;
    logic                   s_tready;
    // iter_whole, iter_frac, point_inside, entry_slot, entry_rgb (lowest bit up)
    logic [IDATA_W-1:0]     s_tdata;
    // opcode
    logic [0:0]             s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // out_red, out_green, out_blue (lowest bit up)
    logic [ODATA_W-1:0]     m_tdata;
    // was_inside
    logic [0:0]             m_tuser;

    // predictor state: palette copy and register copies
    logic [RGB_W-1:0]       pal_mem [0:PAL_DEPTH-1];
    bit                     pal_known [0:PAL_DEPTH-1];
    logic [WHOLE_W-1:0]     limit_copy;
    logic [RGB_W-1:0]       inside_copy;

    color_t                 color_q [$];
    int                     mismatches;
    int                     tx_idle_pct;
    int                     rx_idle_pct;
    int                     rx_hold_left;
    int                     cycle_cnt;

    palette_interp_colorizer u_top (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    // clock
    always #2 aclk = ~aclk;

    // run limit
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("** palette_interp_colorizer: FAILED **");
            $finish;
        end
    end

    // one channel blend, rounded and truncated toward zero
    function automatic logic [CHAN_W-1:0] blend_chan(input logic [CHAN_W-1:0] c1,
                                                     input logic [CHAN_W-1:0] c2,
                                                     input logic [IFRAC_W-1:0] frac);
        int diff;
        int num;
        int q;
        diff = int'(c2) - int'(c1);
        num  = int'(frac & FRAC_MASK) * diff + FRAC_HALF;
        if (num >= 0)
            q = num >>> FRAC_BITS;
        else
            q = -((-num) >>> FRAC_BITS);
        return CHAN_W'(int'(c1) + q);
    endfunction

    // expected color for a map item
    function automatic color_t predict_color(input pix_item_t it);
        color_t c;
        int     i;
        int     j;
        if (it.is_in || it.whole >= limit_copy) begin
            c.red    = inside_copy[23:16];
            c.green  = inside_copy[15:8];
            c.blue   = inside_copy[7:0];
            c.was_in = 1'b1;
        end else begin
            i = it.whole % PAL_DEPTH;
            j = (i == PAL_DEPTH - 1) ? 0 : i + 1;
            c.red    = blend_chan(pal_mem[i][23:16], pal_mem[j][23:16], it.frac);
            c.green  = blend_chan(pal_mem[i][15:8], pal_mem[j][15:8], it.frac);
            c.blue   = blend_chan(pal_mem[i][7:0], pal_mem[j][7:0], it.frac);
            c.was_in = 1'b0;
        end
        return c;
    endfunction

    // map item would read only written entries, or never reads the palette
    function automatic bit map_is_safe(input pix_item_t it);
        int i;
        i = it.whole % PAL_DEPTH;
        return it.is_in || it.whole >= limit_copy ||
               (pal_known[i] && pal_known[(i + 1) % PAL_DEPTH]);
    endfunction

    // drive one item and wait for its transfer, then update the prediction
    task automatic send_item(input pix_item_t it);
        begin
            @(negedge aclk);
            while ($urandom_range(0, 99) < tx_idle_pct) begin
                s_tvalid <= 1'b0;
                @(negedge aclk);
            end
            s_tvalid <= 1'b1;
            s_tuser  <= it.op;
            s_tdata  <= {it.rgb, it.slot, it.is_in, it.frac, it.whole};
            do @(posedge aclk); while (!s_tready);
            if (it.op == OP_WRITE) begin
                pal_mem[it.slot]   = it.rgb;
                pal_known[it.slot] = 1'b1;
            end else begin
                color_q.push_back(predict_color(it));
            end
        end
    endtask

    task automatic map_item(input logic [WHOLE_W-1:0] whole, input logic [IFRAC_W-1:0] frac,
                            input logic in_flag);
        pix_item_t it;
        begin
            it        = pix_item_t'({$urandom(), $urandom(), $urandom()});
            it.op     = OP_MAP;
            it.whole  = whole;
            it.frac   = frac;
            it.is_in  = in_flag;
            send_item(it);
        end
    endtask

    task automatic write_entry(input logic [PAL_AW-1:0] slot, input logic [RGB_W-1:0] rgb);
        pix_item_t it;
        begin
            it      = pix_item_t'({$urandom(), $urandom(), $urandom()});
            it.op   = OP_WRITE;
            it.slot = slot;
            it.rgb  = rgb;
            send_item(it);
        end
    endtask

    // stop sending and wait until every expected color has come out
    task automatic wait_idle();
        begin
            @(negedge aclk);
            s_tvalid <= 1'b0;
            while (color_q.size() != 0) @(posedge aclk);
            repeat (8) @(posedge aclk);
        end
    endtask

    // register write, only while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [RGB_W-1:0] val);
        begin
            @(negedge aclk);
            cfg_we    <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= val;
            @(posedge aclk);
            if (idx == CFG_ITER_LIMIT)
                limit_copy = val;
            else
                inside_copy = val;
            @(negedge aclk);
            cfg_we <= 1'b0;
        end
    endtask

    // receiver ready, with a long hold-off when requested
    always @(negedge aclk) begin
        if (rx_hold_left != 0)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // hold-off counter
    always @(negedge aclk) begin
        if (rx_hold_left != 0)
            rx_hold_left <= rx_hold_left - 1;
    end

    // result checker
    always @(posedge aclk) begin
        color_t got;
        color_t want;
        if (aresetn && m_tvalid && m_tready) begin
            got = {m_tdata[7:0], m_tdata[15:8], m_tdata[23:16], m_tuser[0]};
            if (color_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected color r=%h g=%h b=%h inside=%b",
                             got.red, got.green, got.blue, got.was_in);
            end else begin
                want = color_q.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("color mismatch: exp r=%h g=%h b=%h inside=%b,",
                                 want.red, want.green, want.blue, want.was_in,
                                 " got r=%h g=%h b=%h inside=%b",
                                 got.red, got.green, got.blue, got.was_in);
                end
            end
        end
    end

    // extremes of the fields, rising and falling blends, wrap and inside cases
    task automatic test_directed_blend();
        begin
            write_entry(7'd0, 24'h000000);
            write_entry(7'd1, 24'hFFFFFF);
            write_entry(7'd2, 24'h80007F);
            write_entry(7'd126, 24'h123456);
            write_entry(7'd127, 24'hFEDCBA);
            map_item(24'd0, 8'd0, 1'b0);
            map_item(24'd0, 8'd255, 1'b0);
            map_item(24'd1, 8'd255, 1'b0);
            map_item(24'd1, 8'd128, 1'b0);
            map_item(24'd1, 8'd1, 1'b0);
            // last entry blends into entry zero
            map_item(24'd127, 8'd128, 1'b0);
            map_item(24'd1023, 8'd77, 1'b0);
            // at the limit and forced inside
            map_item(24'd1024, 8'd0, 1'b0);
            map_item(24'd0, 8'd100, 1'b1);
            map_item(24'hFFFFFF, 8'd255, 1'b1);
            map_item(24'd126, 8'd255, 1'b0);
            wait_idle();
        end
    endtask

    // limit extremes, zero limit sends every point inside
    task automatic test_iteration_limit();
        begin
            write_reg(CFG_INSIDE_RGB, 24'hFFFFFF);
            write_reg(CFG_ITER_LIMIT, 24'd0);
            map_item(24'd0, 8'd0, 1'b0);
            map_item(24'd126, 8'd5, 1'b0);
            wait_idle();
            write_reg(CFG_ITER_LIMIT, 24'd1);
            map_item(24'd0, 8'd50, 1'b0);
            map_item(24'd1, 8'd50, 1'b0);
            wait_idle();
            write_reg(CFG_ITER_LIMIT, 24'hFFFFFF);
            write_reg(CFG_INSIDE_RGB, 24'h5A3C96);
            map_item(24'hFFFFFE, 8'd200, 1'b0);
            map_item(24'hFFFFFF, 8'd200, 1'b0);
            map_item(24'd2, 8'd9, 1'b1);
            wait_idle();
        end
    endtask

    // fill every palette entry
    task automatic test_palette_load();
        int k;
        begin
            for (k = 0; k < PAL_DEPTH; k++)
                write_entry(PAL_AW'(k), ($urandom_range(0, 9) == 0) ? 24'hFFFFFF : 24'($urandom()));
            wait_idle();
        end
    endtask

    // mostly map items with mixed whole ranges, some palette rewrites
    task automatic run_random_mix(input int count);
        pix_item_t it;
        int        n;
        int        sel;
        begin
            for (n = 0; n < count; n++) begin
                it = pix_item_t'({$urandom(), $urandom(), $urandom()});
                sel = $urandom_range(0, 99);
                if (sel < 15) begin
                    it.op = OP_WRITE;
                    if ($urandom_range(0, 4) == 0)
                        it.rgb = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000000;
                end else begin
                    it.op = OP_MAP;
                    sel = $urandom_range(0, 9);
                    if (sel >= 4 && sel < 8)
                        it.whole = WHOLE_W'($urandom_range(0, 2 * 1024));
                    else if (sel >= 8)
                        it.whole = limit_copy + WHOLE_W'($urandom_range(0, 4)) - 24'd2;
                    it.is_in = ($urandom_range(0, 9) == 0);
                    if ($urandom_range(0, 9) == 0)
                        it.frac = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    // never read an unwritten entry: write the lower entry of the pair instead
                    if (!map_is_safe(it)) begin
                        it.op   = OP_WRITE;
                        it.slot = it.whole[PAL_AW-1:0];
                    end
                end
                send_item(it);
            end
            wait_idle();
        end
    endtask

    // receiver fully paused while items keep coming, then back to random stalls
    task automatic test_backpressure();
        begin
            rx_hold_left = 300;
            run_random_mix(40);
            run_random_mix(40);
        end
    endtask

    initial begin
        aclk         = 1'b0;
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_index    = CFG_ITER_LIMIT;
        cfg_wdata    = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tuser      = OP_MAP;
        m_tready     = 1'b0;
        mismatches   = 0;
        cycle_cnt    = 0;
        rx_hold_left = 0;
        tx_idle_pct  = 34;
        rx_idle_pct  = 72;
        limit_copy   = ITER_LIMIT_RST;
        inside_copy  = INSIDE_RGB_RST;
        foreach (pal_known[k]) pal_known[k] = 1'b0;

        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed_blend();
        test_iteration_limit();

        // sender with sparse gaps, receiver mostly stalled
        test_palette_load();
        write_reg(CFG_INSIDE_RGB, 24'h000000);
        run_random_mix(200);
        test_backpressure();

        // sender mostly idle, receiver sparse stalls
        tx_idle_pct = 72;
        rx_idle_pct = 34;
        write_reg(CFG_ITER_LIMIT, 24'($urandom_range(1, 24'hFFFFFF)));
        write_reg(CFG_INSIDE_RGB, 24'hFFFFFF);
        run_random_mix(220);

        // full rate both sides
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        write_reg(CFG_ITER_LIMIT, 24'd1024);
        write_reg(CFG_INSIDE_RGB, 24'($urandom()));
        run_random_mix(200);

        repeat (16) @(posedge aclk);
        if (mismatches == 0 && color_q.size() == 0) begin
            $display("** palette_interp_colorizer: PASSED **");
        end else begin
            $display("** palette_interp_colorizer: FAILED **");
        end
        $finish;
    end

endmodule

FILE: filelist.f
design/pic_pkg.sv
design/pic_chan_blend.sv
design/palette_interp_colorizer.sv
design/pic_checker.sv
tb/tb_palette_interp_colorizer.sv
